// ===== rtl/sam_rfs_pkg.sv =====
// Shared types, character codes and column lookup for the SAM record field splitter.
// No dependencies; compile first.
package sam_rfs_pkg;

   localparam int OFFSET_BITS_DEFAULT = 16;

   localparam int INT_SLOTS = 5;   // FLAG, POS, MAPQ, PNEXT, TLEN
   localparam int OFS_SLOTS = 6;   // RNAME, CIGAR, RNEXT, SEQ, QUAL, tags
   localparam int TAGS_SLOT = 5;

   localparam logic [3:0] LAST_TAB        = 4'd11;  // no splitting past the twelfth field
   localparam logic [3:0] TAGS_ABSENT_TAB = 4'd10;  // line holds exactly eleven fields

   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef enum logic [1:0] {
      PHASE_SKIP   = 2'd0,
      PHASE_DIGITS = 2'd1
   } phase_type;

   // One step of the running integer decode.
   typedef struct packed {
      phase_type   phase;
      logic        negative;
      logic [31:0] acc;
      logic        finish;
      logic [31:0] value;
   } atoi_step_type;

   // Integer slots opened by the tab with this number (one-hot or zero).
   function automatic logic [INT_SLOTS-1:0] int_mask_of_tab(input logic [3:0] tab_num);
      logic [INT_SLOTS-1:0] mask;
      mask = '0;
      case (tab_num)
         4'd0:    mask = 5'b00001;
         4'd2:    mask = 5'b00010;
         4'd3:    mask = 5'b00100;
         4'd6:    mask = 5'b01000;
         4'd7:    mask = 5'b10000;
         default: mask = '0;
      endcase
      return mask;
   endfunction

   // Offset slots opened by the tab with this number (one-hot or zero).
   function automatic logic [OFS_SLOTS-1:0] ofs_mask_of_tab(input logic [3:0] tab_num);
      logic [OFS_SLOTS-1:0] mask;
      mask = '0;
      case (tab_num)
         4'd1:    mask = 6'b000001;
         4'd4:    mask = 6'b000010;
         4'd5:    mask = 6'b000100;
         4'd8:    mask = 6'b001000;
         4'd9:    mask = 6'b010000;
         4'd10:   mask = 6'b100000;
         default: mask = '0;
      endcase
      return mask;
   endfunction

endpackage

// ===== rtl/sam_rfs_if.sv =====
// Valid/ready channels for the SAM record field splitter: byte beats in, records out.
// Depends on sam_rfs_pkg for the default offset width.
interface sam_rfs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       line_end;

   modport source (output valid, output ch, output line_end, input ready);
   modport sink   (input valid, input ch, input line_end, output ready);
endinterface

interface sam_rfs_rsp_if #(
   parameter int OFFSET_BITS = sam_rfs_pkg::OFFSET_BITS_DEFAULT
);
   logic                   valid;
   logic                   ready;
   logic signed [31:0]     flag_value;
   logic signed [31:0]     position_zero_based;
   logic signed [31:0]     mapping_quality;
   logic signed [31:0]     mate_position_zero_based;
   logic signed [31:0]     template_length;
   logic [OFFSET_BITS-1:0] reference_offset;
   logic [OFFSET_BITS-1:0] cigar_offset;
   logic [OFFSET_BITS-1:0] mate_reference_offset;
   logic [OFFSET_BITS-1:0] sequence_offset;
   logic [OFFSET_BITS-1:0] quality_offset;
   logic [OFFSET_BITS-1:0] tags_offset;
   logic [3:0]             field_count;

   modport source (
      output valid, input ready,
      output flag_value, output position_zero_based, output mapping_quality,
      output mate_position_zero_based, output template_length,
      output reference_offset, output cigar_offset, output mate_reference_offset,
      output sequence_offset, output quality_offset, output tags_offset,
      output field_count
   );
   modport sink (
      input valid, output ready,
      input flag_value, input position_zero_based, input mapping_quality,
      input mate_position_zero_based, input template_length,
      input reference_offset, input cigar_offset, input mate_reference_offset,
      input sequence_offset, input quality_offset, input tags_offset,
      input field_count
   );
endinterface

// ===== rtl/sam_rfs_atoi.sv =====
// One byte step of the atoi-style decimal decoder (blanks, sign, digits, wrap at 32 bits).
// Depends on sam_rfs_pkg.
module sam_rfs_atoi (
   input  logic                   active,
   input  logic [7:0]             ch,
   input  sam_rfs_pkg::phase_type phase,
   input  logic                   negative,
   input  logic [31:0]            acc,
   output sam_rfs_pkg::atoi_step_type step
);

   logic        is_blank;
   logic        is_digit;
   logic        is_sign;
   logic [31:0] digit;
   logic [31:0] acc_times_ten;

   assign is_blank = ch inside {[sam_rfs_pkg::CHAR_TAB:sam_rfs_pkg::CHAR_CR],
                                sam_rfs_pkg::CHAR_SPACE};
   assign is_digit = ch inside {[sam_rfs_pkg::CHAR_ZERO:sam_rfs_pkg::CHAR_NINE]};
   assign is_sign  = (ch == sam_rfs_pkg::CHAR_PLUS) || (ch == sam_rfs_pkg::CHAR_MINUS);
   assign digit    = {28'd0, ch[3:0]};
   assign acc_times_ten = {acc[28:0], 3'b000} + {acc[30:0], 1'b0};

   always_comb begin
      step.phase    = phase;
      step.negative = negative;
      step.acc      = acc;
      step.finish   = 1'b0;
      step.value    = negative ? (32'd0 - acc) : acc;
      if (active) begin
         if (phase == sam_rfs_pkg::PHASE_SKIP) begin
            if (is_blank) begin
               // hold, still skipping
            end else if (is_sign) begin
               step.phase    = sam_rfs_pkg::PHASE_DIGITS;
               step.negative = (ch == sam_rfs_pkg::CHAR_MINUS);
            end else if (is_digit) begin
               step.phase = sam_rfs_pkg::PHASE_DIGITS;
               step.acc   = digit;
            end else begin
               step.finish = 1'b1;
            end
         end else begin
            if (is_digit) begin
               step.acc = acc_times_ten + digit;
            end else begin
               step.finish = 1'b1;
            end
         end
      end
      if (step.finish) begin
         step.phase    = sam_rfs_pkg::PHASE_SKIP;
         step.negative = 1'b0;
         step.acc      = '0;
      end
   end

endmodule

// ===== rtl/sam_rfs_field_splitter_core.sv =====
// Holds no logic; the top level lives in sam_record_field_splitter_core.sv.
// No dependencies.

// ===== rtl/sam_record_field_splitter_core.sv =====
// SAM record field splitter, top level. Depends on sam_rfs_pkg, sam_rfs_if, sam_rfs_atoi.
//
// Feed one byte of a tab-separated SAM alignment line per req beat, with line_end set
// on the line's final byte; one record comes out on rsp for every line. The block takes
// a beat every cycle unless stalled as below: each beat lands in an input register, from
// which a single pass of compare and multiply-by-ten logic updates the line state and,
// on the last byte, loads the output register, where the record then appears on rsp.
// The input stalls only while a finished record sits unclaimed in the output register
// and another last byte is waiting behind it. Integer columns (FLAG, POS, MAPQ, PNEXT,
// TLEN) decode with atoi rules and wrap at 32 bits; POS and PNEXT come out minus one.
// Offsets count bytes from the line start and wrap at OFFSET_BITS. After reset the
// block is ready at once; there is no clearing pass.
module sam_record_field_splitter_core #(
   parameter int OFFSET_BITS = sam_rfs_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   sam_rfs_req_if.sink   req_if,
   sam_rfs_rsp_if.source rsp_if
);

   localparam int NI = sam_rfs_pkg::INT_SLOTS;
   localparam int NO = sam_rfs_pkg::OFS_SLOTS;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_ch_ff;
   logic       in_last_ff;

   // line state
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [3:0]             field_ff, field_in;
   logic [31:0]            acc_ff, acc_in;
   sam_rfs_pkg::phase_type phase_ff, phase_in;
   logic                   neg_ff, neg_in;
   logic [NI-1:0]          wait_ff, wait_in;
   logic [31:0]            ints_ff [NI];
   logic [31:0]            ints_in [NI];
   logic [OFFSET_BITS-1:0] ofs_ff [NO];
   logic [OFFSET_BITS-1:0] ofs_in [NO];
   logic [OFFSET_BITS-1:0] trim_ff, trim_in;

   // output register
   logic                   out_valid_ff, out_valid_in;
   logic [31:0]            out_ints_ff [NI];
   logic [31:0]            out_ints_in [NI];
   logic [OFFSET_BITS-1:0] out_ofs_ff [NO];
   logic [OFFSET_BITS-1:0] out_ofs_in [NO];
   logic [3:0]             out_count_ff, out_count_in;

   logic                   out_free;
   logic                   advance;
   logic [OFFSET_BITS-1:0] next_pos;
   logic [NO-1:0]          ofs_open;
   logic [31:0]            tail_value;
   sam_rfs_pkg::atoi_step_type dec;

   sam_rfs_atoi u_atoi (
      .active   (wait_ff != '0),
      .ch       (in_ch_ff),
      .phase    (phase_ff),
      .negative (neg_ff),
      .acc      (acc_ff),
      .step     (dec)
   );

   // A last byte needs the output register; any other byte always moves on.
   assign out_free = !out_valid_ff || rsp_if.ready;
   assign advance  = in_valid_ff && (!in_last_ff || out_free);
   assign req_if.ready = !in_valid_ff || advance;
   assign next_pos = pos_ff + OFFSET_BITS'(1);
   assign ofs_open = sam_rfs_pkg::ofs_mask_of_tab(field_ff);

   always_comb begin
      in_valid_in = req_if.ready ? req_if.valid : in_valid_ff;
      out_valid_in = out_valid_ff && !rsp_if.ready;

      pos_in   = pos_ff;
      field_in = field_ff;
      acc_in   = acc_ff;
      phase_in = phase_ff;
      neg_in   = neg_ff;
      wait_in  = wait_ff;
      trim_in  = trim_ff;
      ints_in  = ints_ff;
      ofs_in   = ofs_ff;
      out_ints_in  = out_ints_ff;
      out_ofs_in   = out_ofs_ff;
      out_count_in = out_count_ff;
      tail_value   = '0;

      if (advance) begin
         // running decode: deliver the value to every slot waiting on it
         acc_in   = dec.acc;
         phase_in = dec.phase;
         neg_in   = dec.negative;
         if (dec.finish) begin
            for (int i = 0; i < NI; i++) begin
               if (wait_ff[i]) ints_in[i] = dec.value;
            end
            wait_in = '0;
         end

         // field split: a tab opens either an integer column or an offset column
         if (in_ch_ff == sam_rfs_pkg::CHAR_TAB && field_ff < sam_rfs_pkg::LAST_TAB) begin
            wait_in = wait_in | sam_rfs_pkg::int_mask_of_tab(field_ff);
            for (int i = 0; i < NO; i++) begin
               if (ofs_open[i]) ofs_in[i] = next_pos;
            end
            field_in = field_ff + 4'd1;
         end

         if (in_ch_ff != sam_rfs_pkg::CHAR_CR && in_ch_ff != sam_rfs_pkg::CHAR_LF) begin
            trim_in = next_pos;
         end

         pos_in = next_pos;

         if (in_last_ff) begin
            // close a decode still open at the line's end
            tail_value = neg_in ? (32'd0 - acc_in) : acc_in;
            for (int i = 0; i < NI; i++) begin
               if (wait_in[i]) ints_in[i] = tail_value;
            end
            if (field_in == sam_rfs_pkg::TAGS_ABSENT_TAB) begin
               ofs_in[sam_rfs_pkg::TAGS_SLOT] = trim_in;
            end

            out_valid_in = 1'b1;
            out_ints_in  = ints_in;
            out_ints_in[1] = ints_in[1] - 32'd1;
            out_ints_in[3] = ints_in[3] - 32'd1;
            out_ofs_in   = ofs_in;
            out_count_in = field_in + 4'd1;

            // clear for the next line
            pos_in   = '0;
            field_in = '0;
            acc_in   = '0;
            phase_in = sam_rfs_pkg::PHASE_SKIP;
            neg_in   = 1'b0;
            wait_in  = '0;
            trim_in  = '0;
            for (int i = 0; i < NI; i++) ints_in[i] = '0;
            for (int i = 0; i < NO; i++) ofs_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff   <= '0;
         field_ff <= '0;
         acc_ff   <= '0;
         phase_ff <= sam_rfs_pkg::PHASE_SKIP;
         neg_ff   <= 1'b0;
         wait_ff  <= '0;
         trim_ff  <= '0;
         for (int i = 0; i < NI; i++) ints_ff[i] <= '0;
         for (int i = 0; i < NO; i++) ofs_ff[i] <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         pos_ff   <= pos_in;
         field_ff <= field_in;
         acc_ff   <= acc_in;
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         wait_ff  <= wait_in;
         trim_ff  <= trim_in;
         ints_ff  <= ints_in;
         ofs_ff   <= ofs_in;
      end
   end

   // payload registers: hold unless a beat is taken or a record is loaded
   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         in_ch_ff   <= req_if.ch;
         in_last_ff <= req_if.line_end;
      end
      out_ints_ff  <= out_ints_in;
      out_ofs_ff   <= out_ofs_in;
      out_count_ff <= out_count_in;
   end

   assign rsp_if.valid                    = out_valid_ff;
   assign rsp_if.flag_value               = out_ints_ff[0];
   assign rsp_if.position_zero_based      = out_ints_ff[1];
   assign rsp_if.mapping_quality          = out_ints_ff[2];
   assign rsp_if.mate_position_zero_based = out_ints_ff[3];
   assign rsp_if.template_length          = out_ints_ff[4];
   assign rsp_if.reference_offset         = out_ofs_ff[0];
   assign rsp_if.cigar_offset             = out_ofs_ff[1];
   assign rsp_if.mate_reference_offset    = out_ofs_ff[2];
   assign rsp_if.sequence_offset          = out_ofs_ff[3];
   assign rsp_if.quality_offset           = out_ofs_ff[4];
   assign rsp_if.tags_offset              = out_ofs_ff[5];
   assign rsp_if.field_count              = out_count_ff;

endmodule

// ===== tb/tb_sam_record_field_splitter_core.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sam_record_field_splitter_core: feeds SAM text lines byte by byte
// and checks every record against a predictor of the splitter. Needs sam_rfs_pkg, sam_rfs_if.
module tb_sam_record_field_splitter_core;

   localparam int OFS_W       = sam_rfs_pkg::OFFSET_BITS_DEFAULT;
   localparam int QUIET_LIMIT = 2000;  // cycles without any beat before giving up
   localparam int SETTLE      = 6;     // margin after the expected records have all been checked
   localparam int RANDOM_BYTES     = 320;
   localparam int RANDOM_LINES_MIN = 8;

   // Zero-based SAM columns that a tab can open.
   localparam int COL_FLAG  = 1;
   localparam int COL_RNAME = 2;
   localparam int COL_POS   = 3;
   localparam int COL_MAPQ  = 4;
   localparam int COL_CIGAR = 5;
   localparam int COL_RNEXT = 6;
   localparam int COL_PNEXT = 7;
   localparam int COL_TLEN  = 8;
   localparam int COL_SEQ   = 9;
   localparam int COL_QUAL  = 10;
   localparam int COL_TAGS  = 11;

   // Integer and offset slot indexes.
   localparam int SLOT_FLAG  = 0;
   localparam int SLOT_POS   = 1;
   localparam int SLOT_MAPQ  = 2;
   localparam int SLOT_PNEXT = 3;
   localparam int SLOT_TLEN  = 4;
   localparam int START_RNAME = 0;
   localparam int START_CIGAR = 1;
   localparam int START_RNEXT = 2;
   localparam int START_SEQ   = 3;
   localparam int START_QUAL  = 4;
   localparam int START_TAGS  = 5;

   localparam logic [7:0] CHAR_VT = 8'h0B;
   localparam logic [7:0] CHAR_FF = 8'h0C;
   localparam logic [7:0] CHAR_NUL = 8'h00;

   typedef struct {
      logic signed [31:0] flag_value;
      logic signed [31:0] position_zero_based;
      logic signed [31:0] mapping_quality;
      logic signed [31:0] mate_position_zero_based;
      logic signed [31:0] template_length;
      logic [OFS_W-1:0]   reference_offset;
      logic [OFS_W-1:0]   cigar_offset;
      logic [OFS_W-1:0]   mate_reference_offset;
      logic [OFS_W-1:0]   sequence_offset;
      logic [OFS_W-1:0]   quality_offset;
      logic [OFS_W-1:0]   tags_offset;
      logic [3:0]         field_count;
   } sam_record_type;

   logic clock;
   logic reset;

   sam_rfs_req_if                         req_chan ();
   sam_rfs_rsp_if #(.OFFSET_BITS(OFS_W))  rsp_chan ();

   sam_record_field_splitter_core #(.OFFSET_BITS(OFS_W)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan)
   );

   // ------------------------------------------------------------------
   // Line splitter predictor: its own copy of the per-line state.
   // ------------------------------------------------------------------
   logic [OFS_W-1:0]     line_pos;
   logic [3:0]           tabs_seen;
   logic [31:0]          num_acc;
   sam_rfs_pkg::phase_type num_phase;
   logic                 num_neg;
   logic [sam_rfs_pkg::INT_SLOTS-1:0] slots_waiting;  // integer columns fed by the decode
   logic [31:0]          int_fields [sam_rfs_pkg::INT_SLOTS];
   logic [OFS_W-1:0]     col_starts [sam_rfs_pkg::OFS_SLOTS];
   logic [OFS_W-1:0]     trim_len;         // length without trailing CR/LF

   sam_record_type expected_records [$];

   int error_count;
   int records_checked;
   int bytes_sent;
   int lines_sent;
   bit quiet_line;
   logic [7:0] line_bytes [$];

   function automatic bit is_blank_char(input logic [7:0] c);
      return c == sam_rfs_pkg::CHAR_SPACE ||
             (c >= sam_rfs_pkg::CHAR_TAB && c <= sam_rfs_pkg::CHAR_CR);
   endfunction

   function automatic bit is_digit_char(input logic [7:0] c);
      return c >= sam_rfs_pkg::CHAR_ZERO && c <= sam_rfs_pkg::CHAR_NINE;
   endfunction

   task automatic clear_line_state();
      line_pos      = '0;
      tabs_seen     = '0;
      num_acc       = '0;
      num_phase     = sam_rfs_pkg::PHASE_SKIP;
      num_neg       = 1'b0;
      slots_waiting = '0;
      trim_len      = '0;
      for (int i = 0; i < sam_rfs_pkg::INT_SLOTS; i++) int_fields[i] = '0;
      for (int i = 0; i < sam_rfs_pkg::OFS_SLOTS; i++) col_starts[i] = '0;
   endtask

   // Hand the decoded value to every integer column still waiting on it.
   task automatic close_number();
      logic [31:0] value;
      value = num_neg ? (32'd0 - num_acc) : num_acc;
      for (int i = 0; i < sam_rfs_pkg::INT_SLOTS; i++)
         if (slots_waiting[i]) int_fields[i] = value;
      slots_waiting = '0;
      num_acc       = '0;
      num_phase     = sam_rfs_pkg::PHASE_SKIP;
      num_neg       = 1'b0;
   endtask

   task automatic split_byte(input logic [7:0] c, input logic last);
      logic [OFS_W-1:0] next_pos;
      sam_record_type   rec;
      next_pos = line_pos + OFS_W'(1);

      // advance the running decode first; a tab may both end it and open a new column
      if (slots_waiting != '0) begin
         if (num_phase == sam_rfs_pkg::PHASE_SKIP) begin
            if (is_blank_char(c)) begin
               // keep skipping
            end else if (c == sam_rfs_pkg::CHAR_PLUS || c == sam_rfs_pkg::CHAR_MINUS) begin
               num_phase = sam_rfs_pkg::PHASE_DIGITS;
               num_neg   = (c == sam_rfs_pkg::CHAR_MINUS);
            end else if (is_digit_char(c)) begin
               num_phase = sam_rfs_pkg::PHASE_DIGITS;
               num_acc   = 32'(c - sam_rfs_pkg::CHAR_ZERO);
            end else begin
               close_number();
            end
         end else if (is_digit_char(c)) begin
            num_acc = num_acc * 32'd10 + 32'(c - sam_rfs_pkg::CHAR_ZERO);
         end else begin
            close_number();
         end
      end

      if (c == sam_rfs_pkg::CHAR_TAB && tabs_seen < sam_rfs_pkg::LAST_TAB) begin
         case (int'(tabs_seen) + 1)
            COL_FLAG:  slots_waiting[SLOT_FLAG]  = 1'b1;
            COL_POS:   slots_waiting[SLOT_POS]   = 1'b1;
            COL_MAPQ:  slots_waiting[SLOT_MAPQ]  = 1'b1;
            COL_PNEXT: slots_waiting[SLOT_PNEXT] = 1'b1;
            COL_TLEN:  slots_waiting[SLOT_TLEN]  = 1'b1;
            COL_RNAME: col_starts[START_RNAME] = next_pos;
            COL_CIGAR: col_starts[START_CIGAR] = next_pos;
            COL_RNEXT: col_starts[START_RNEXT] = next_pos;
            COL_SEQ:   col_starts[START_SEQ]   = next_pos;
            COL_QUAL:  col_starts[START_QUAL]  = next_pos;
            COL_TAGS:  col_starts[START_TAGS]  = next_pos;
            default: ;
         endcase
         tabs_seen++;
      end

      if (c != sam_rfs_pkg::CHAR_CR && c != sam_rfs_pkg::CHAR_LF) trim_len = next_pos;

      if (!last) begin
         line_pos = next_pos;
      end else begin
         if (slots_waiting != '0) close_number();
         // exactly eleven fields: tags start where the trimmed line ends
         if (tabs_seen == sam_rfs_pkg::TAGS_ABSENT_TAB) col_starts[START_TAGS] = trim_len;
         rec.flag_value               = int_fields[SLOT_FLAG];
         rec.position_zero_based      = int_fields[SLOT_POS] - 32'd1;
         rec.mapping_quality          = int_fields[SLOT_MAPQ];
         rec.mate_position_zero_based = int_fields[SLOT_PNEXT] - 32'd1;
         rec.template_length          = int_fields[SLOT_TLEN];
         rec.reference_offset         = col_starts[START_RNAME];
         rec.cigar_offset             = col_starts[START_CIGAR];
         rec.mate_reference_offset    = col_starts[START_RNEXT];
         rec.sequence_offset          = col_starts[START_SEQ];
         rec.quality_offset           = col_starts[START_QUAL];
         rec.tags_offset              = col_starts[START_TAGS];
         rec.field_count              = tabs_seen + 4'd1;
         expected_records.push_back(rec);
         clear_line_state();
      end
   endtask

   // ------------------------------------------------------------------
   // Reporting and checking
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      error_count++;
      $display("mismatch: %s", msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("record %0d %s: got %0h, want %0h",
                                   records_checked, name, got, want));
   endtask

   // Predict on every accepted byte beat.
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         split_byte(req_chan.ch, req_chan.line_end);
   end

   // Compare every accepted record beat with the oldest expected record.
   always @(posedge clock) begin : record_checker
      sam_record_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_records.size() == 0) begin
            report_mismatch($sformatf("record %0d arrived with no line waiting",
                                      records_checked));
         end else begin
            want = expected_records.pop_front();
            check_field("flag_value", rsp_chan.flag_value, want.flag_value);
            check_field("position_zero_based", rsp_chan.position_zero_based,
                        want.position_zero_based);
            check_field("mapping_quality", rsp_chan.mapping_quality, want.mapping_quality);
            check_field("mate_position_zero_based", rsp_chan.mate_position_zero_based,
                        want.mate_position_zero_based);
            check_field("template_length", rsp_chan.template_length, want.template_length);
            check_field("reference_offset", rsp_chan.reference_offset, want.reference_offset);
            check_field("cigar_offset", rsp_chan.cigar_offset, want.cigar_offset);
            check_field("mate_reference_offset", rsp_chan.mate_reference_offset,
                        want.mate_reference_offset);
            check_field("sequence_offset", rsp_chan.sequence_offset, want.sequence_offset);
            check_field("quality_offset", rsp_chan.quality_offset, want.quality_offset);
            check_field("tags_offset", rsp_chan.tags_offset, want.tags_offset);
            check_field("field_count", rsp_chan.field_count, want.field_count);
         end
         records_checked++;
      end
   end

   // ------------------------------------------------------------------
   // Clock, record sink stalls, watchdog
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Mostly short gaps, a few long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   initial begin : record_sink
      int stall_left;
      int calm_left;
      stall_left = 0;
      calm_left  = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
            // now and then take a long stretch with no back-pressure at all
            if (calm_left > 0) calm_left--;
            else if ($urandom_range(0, 99) < 3) calm_left = $urandom_range(50, 300);
            else if ($urandom_range(0, 99) < 30) stall_left = pick_gap();
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no beat for %0d cycles, %0d records outstanding",
               QUIET_LIMIT, expected_records.size());
      $display("status: fail");
      $finish;
   end

   // ------------------------------------------------------------------
   // Byte driver and line builders
   // ------------------------------------------------------------------
   // Drive one byte beat and hold it until accepted. Valid stays high afterwards so a
   // following byte can go out back to back; callers that wait must drop it first.
   task automatic send_byte(input logic [7:0] value, input logic last);
      int gap;
      gap = (quiet_line || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.ch       <= value;
      req_chan.line_end <= last;
      do @(posedge clock); while (!req_chan.ready);
      bytes_sent++;
   endtask

   task automatic send_line();
      quiet_line = ($urandom_range(0, 3) == 0);
      foreach (line_bytes[i]) send_byte(line_bytes[i], i == line_bytes.size() - 1);
      lines_sent++;
   endtask

   // Pause the byte stream until every outstanding record has been checked.
   task automatic wait_records_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_records.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
   endtask

   task automatic send_text(input string s);
      line_bytes.delete();
      push_text(s);
      send_line();
   endtask

   // Printable, non-blank characters; digits and signs included on purpose.
   task automatic push_word(input int lo, input int hi);
      repeat ($urandom_range(lo, hi)) line_bytes.push_back(8'($urandom_range(33, 126)));
   endtask

   // Decimal field with optional leading blanks, sign, long runs and trailing junk.
   task automatic push_number();
      int r;
      int ndigits;
      r = $urandom_range(0, 9);
      if (r >= 7) begin
         repeat ($urandom_range(1, 2)) begin
            case ($urandom_range(0, 2))
               0:       line_bytes.push_back(sam_rfs_pkg::CHAR_SPACE);
               1:       line_bytes.push_back(CHAR_VT);
               default: line_bytes.push_back(CHAR_FF);
            endcase
         end
      end
      r = $urandom_range(0, 99);
      if (r < 15) line_bytes.push_back(sam_rfs_pkg::CHAR_MINUS);
      else if (r < 22) line_bytes.push_back(sam_rfs_pkg::CHAR_PLUS);
      r = $urandom_range(0, 99);
      if (r < 8) ndigits = 0;
      else if (r < 80) ndigits = $urandom_range(1, 4);
      else ndigits = $urandom_range(5, 12);
      repeat (ndigits)
         line_bytes.push_back(sam_rfs_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 9) == 0) push_word(1, 2);
   endtask

   task automatic push_line_ending();
      case ($urandom_range(0, 3))
         0: ;
         1: line_bytes.push_back(sam_rfs_pkg::CHAR_LF);
         2: begin
            line_bytes.push_back(sam_rfs_pkg::CHAR_CR);
            line_bytes.push_back(sam_rfs_pkg::CHAR_LF);
         end
         default: line_bytes.push_back(sam_rfs_pkg::CHAR_CR);
      endcase
   endtask

   // Well-formed alignment line: eleven columns, optional tags, random ending.
   task automatic build_sam_line();
      line_bytes.delete();
      push_word(1, 6); line_bytes.push_back(sam_rfs_pkg::CHAR_TAB);
      push_number();   line_bytes.push_back(sam_rfs_pkg::CHAR_TAB);
      push_word(0, 4); line_bytes.push_back(sam_rfs_pkg::CHAR_TAB);
      push_number();   line_bytes.push_back(sam_rfs_pkg::CHAR_TAB);
      push_number();   line_bytes.push_back(sam_rfs_pkg::CHAR_TAB);
      push_word(0, 5); line_bytes.push_back(sam_rfs_pkg::CHAR_TAB);
      push_word(0, 3); line_bytes.push_back(sam_rfs_pkg::CHAR_TAB);
      push_number();   line_bytes.push_back(sam_rfs_pkg::CHAR_TAB);
      push_number();   line_bytes.push_back(sam_rfs_pkg::CHAR_TAB);
      push_word(0, 6); line_bytes.push_back(sam_rfs_pkg::CHAR_TAB);
      push_word(0, 6);
      if ($urandom_range(0, 1) == 1) begin
         line_bytes.push_back(sam_rfs_pkg::CHAR_TAB);
         push_word(1, 6);
         if ($urandom_range(0, 2) == 0) begin
            line_bytes.push_back(sam_rfs_pkg::CHAR_TAB);
            push_word(1, 6);
         end
      end
      push_line_ending();
   endtask

   // Random bytes weighted toward tabs, digits, blanks and signs.
   task automatic build_noise_line();
      int r;
      line_bytes.delete();
      repeat ($urandom_range(1, 30)) begin
         r = $urandom_range(0, 99);
         if (r < 25) line_bytes.push_back(sam_rfs_pkg::CHAR_TAB);
         else if (r < 45)
            line_bytes.push_back(sam_rfs_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
         else if (r < 55)
            line_bytes.push_back(8'($urandom_range(sam_rfs_pkg::CHAR_LF, sam_rfs_pkg::CHAR_CR)));
         else if (r < 60) line_bytes.push_back(sam_rfs_pkg::CHAR_SPACE);
         else if (r < 68)
            line_bytes.push_back($urandom_range(0, 1) ? sam_rfs_pkg::CHAR_MINUS
                                                      : sam_rfs_pkg::CHAR_PLUS);
         else if (r < 72) line_bytes.push_back(CHAR_NUL);
         else line_bytes.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   // More than twelve fields: splitting must stop after the twelfth.
   task automatic build_overfull_line();
      line_bytes.delete();
      repeat ($urandom_range(12, 16)) begin
         if ($urandom_range(0, 1) == 1) push_number();
         else push_word(0, 3);
         line_bytes.push_back(sam_rfs_pkg::CHAR_TAB);
      end
      push_word(0, 3);
      push_line_ending();
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_basic_record();
      line_bytes.delete();
      push_text("r001\t99\tchr1\t7\t30\t8M2I4M1D3M\t=\t37\t39\tTTAGATAAAGG\t*\tNM:i:1");
      line_bytes.push_back(sam_rfs_pkg::CHAR_LF);
      send_line();
      line_bytes.delete();
      push_text("r002\t0\tchr2\t9\t30\t3S6M\t*\t0\t0\tAAAAGATAA\tIIIIIIIII\tNM:i:0\tMD:Z:6");
      line_bytes.push_back(sam_rfs_pkg::CHAR_CR);
      line_bytes.push_back(sam_rfs_pkg::CHAR_LF);
      send_line();
   endtask

   task automatic test_integer_extremes();
      // largest and smallest 32-bit values, POS of one, PNEXT of zero, wrap past 2^32
      send_text("q\t2147483647\tr\t1\t-2147483648\tc\t*\t0\t4294967297");
      send_text("q\t-2147483649\tr\t4294967295\t0000255\tc\t*\t2147483648\t-1");
      // leading blanks, plus sign, junk after digits, lone signs, huge run of digits
      line_bytes.delete();
      push_text("q\t +12x\tr\t");
      line_bytes.push_back(CHAR_VT);
      line_bytes.push_back(CHAR_FF);
      push_text(" -0\t+\tc\t*\t-\t99999999999");
      send_line();
   endtask

   task automatic test_missing_fields();
      send_text("A");
      line_bytes.delete();
      line_bytes.push_back(sam_rfs_pkg::CHAR_LF);
      send_line();
      line_bytes.delete();
      line_bytes.push_back(sam_rfs_pkg::CHAR_CR);
      send_line();
      // exactly eleven fields: tags offset falls back to the trimmed length
      line_bytes.delete();
      push_text("q\tf\tr\tp\tm\tc\tn\tx\tt\ts\tqq");
      line_bytes.push_back(sam_rfs_pkg::CHAR_CR);
      line_bytes.push_back(sam_rfs_pkg::CHAR_LF);
      send_line();
      send_text("q\t1\tr\t2\t3\tc\t*\t4\t5\ts\tq");
      // CR/LF inside the last field is not trimmed, only the trailing ones
      line_bytes.delete();
      push_text("q\t1\tr\t2\t3\tc\t*\t4\t5\ts\ta");
      line_bytes.push_back(sam_rfs_pkg::CHAR_LF);
      push_text("b");
      line_bytes.push_back(sam_rfs_pkg::CHAR_LF);
      line_bytes.push_back(sam_rfs_pkg::CHAR_CR);
      send_line();
      send_text("q\t1\tr\t2\t3\tc\t*\t4\t5\ts");
      send_text("q\t5\tr");
   endtask

   task automatic test_shared_decode();
      // empty POS column: POS and MAPQ share one decode
      send_text("q\t1\tr\t\t42\tc");
      // all tabs: every integer column waits for the one value at the end
      send_text("\t\t\t\t\t\t\t\t\t\t\t\t\t\t 99");
      // decode of TLEN runs on past the twelfth field
      send_text("q\t1\tr\t2\t3\tc\t*\t4\t\t\t\t\t\t-5");
      // a NUL byte ends a number like any other non-digit
      line_bytes.delete();
      push_text("q\t12");
      line_bytes.push_back(CHAR_NUL);
      push_text("3\tr\t8");
      send_line();
   endtask

   task automatic test_random_lines();
      int start_bytes;
      int lines_done;
      int r;
      start_bytes = bytes_sent;
      lines_done  = 0;
      while (bytes_sent - start_bytes < RANDOM_BYTES || lines_done < RANDOM_LINES_MIN) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            build_sam_line();
         end else if (r < 80) begin
            // cut a good line short anywhere
            build_sam_line();
            r = $urandom_range(1, line_bytes.size());
            while (line_bytes.size() > r) void'(line_bytes.pop_back());
         end else if (r < 92) begin
            build_noise_line();
         end else begin
            build_overfull_line();
         end
         send_line();
         lines_done++;
         if (lines_done % 4 == 0) wait_records_drained();
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin : test_sequence
      error_count     = 0;
      records_checked = 0;
      bytes_sent      = 0;
      lines_sent      = 0;
      quiet_line      = 1'b0;
      clear_line_state();
      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.ch       <= '0;
      req_chan.line_end <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_basic_record();
      wait_records_drained();
      test_integer_extremes();
      wait_records_drained();
      test_missing_fields();
      wait_records_drained();
      test_shared_decode();
      wait_records_drained();
      test_random_lines();
      wait_records_drained();

      if (expected_records.size() != 0)
         report_mismatch($sformatf("%0d records never arrived", expected_records.size()));

      $display("covered %0d lines in %0d byte beats: SAM records, integer limits, short,",
               lines_sent, bytes_sent);
      $display("overfull and noisy lines; %0d records checked, %0d mismatches",
               records_checked, error_count);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
